>>> hdl/svq_pkg.sv
// ----------------------------------------------------------------------------
// svq_pkg
// Shared types and constants of the sorted value queue.
// ----------------------------------------------------------------------------
package svq_pkg;

	// storage depth and data width
	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;

	// smallest value reported when the store is empty
	localparam logic signed [DATA_W-1:0] EMPTY_MARK = 32'sh8000_0001;

	// request operation codes
	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_POP    = 2'd2
	} func_t;

	// operation broadcast to every cell
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2,
		CELL_POP    = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t                   op;
		logic signed [DATA_W-1:0]   key;
	} cell_cmd_t;

	// compare flags a cell reports
	typedef struct packed {
		logic le;   // holds a value at or below the key
		logic eq;   // holds a value equal to the key
	} cell_flags_t;

endpackage

>>> hdl/svq_cell.sv
// ----------------------------------------------------------------------------
// svq_cell
// One slot of the sorted chain: holds a value, compares it with the key and
// takes a value from its left or right neighbor when the row shifts.
// ----------------------------------------------------------------------------
module svq_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  svq_pkg::cell_cmd_t                  cmd,
	input  logic signed [svq_pkg::DATA_W-1:0]   left_val,
	input  logic                                left_vld,
	input  logic                                left_le,
	input  logic signed [svq_pkg::DATA_W-1:0]   right_val,
	input  logic                                right_vld,
	output logic signed [svq_pkg::DATA_W-1:0]   val,
	output logic                                vld,
	output svq_pkg::cell_flags_t                flags
);

	logic signed [svq_pkg::DATA_W-1:0] val_q;
	logic                              vld_q;
	logic                              lt;

	// compare against the broadcast key
	always_comb begin
		flags.le = vld_q && (val_q <= cmd.key);
		flags.eq = vld_q && (val_q == cmd.key);
		lt       = vld_q && (val_q < cmd.key);
	end

	// valid bit: grows on insert, shrinks from the right on removal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			case (cmd.op)
				svq_pkg::CELL_INSERT: vld_q <= vld_q | left_vld;
				svq_pkg::CELL_REMOVE: begin
					if (!lt) vld_q <= right_vld;
				end
				svq_pkg::CELL_POP:    vld_q <= right_vld;
				default:              vld_q <= vld_q;
			endcase
		end
	end

	// value: stays, takes the key, or takes a neighbor
	always_ff @(posedge clk) begin
		case (cmd.op)
			svq_pkg::CELL_INSERT: begin
				if (!flags.le) val_q <= left_le ? cmd.key : left_val;
			end
			svq_pkg::CELL_REMOVE: begin
				if (!lt) val_q <= right_val;
			end
			svq_pkg::CELL_POP:    val_q <= right_val;
			default:              val_q <= val_q;
		endcase
	end

	assign val = val_q;
	assign vld = vld_q;

endmodule

>>> hdl/sorted_value_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_value_queue_unit
// Bounded ascending store of signed values with insert, remove and pop.
// ----------------------------------------------------------------------------
// On every request (start while busy is low) the whole row of cells compares
// against the request value and shifts on the accepting clock edge, so busy
// stays low and a new request may follow in every cycle. The result appears
// in the cycle after the request, marked by done for exactly that cycle; the
// receiver cannot stall it and must take it then. smallest reads the first
// cell, or 0x80000001 when empty; is_empty tells that apart from a stored
// 0x80000001. An insert into a full store is dropped and flagged, a pop on an
// empty store changes nothing.
module sorted_value_queue_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          func,
	input  logic signed [svq_pkg::DATA_W-1:0]   value,
	output logic                                done,
	output logic signed [svq_pkg::DATA_W-1:0]   smallest,
	output logic                                is_empty,
	output logic                                not_found,
	output logic                                dropped
);

	localparam int N = svq_pkg::CAPACITY;

	svq_pkg::cell_cmd_t               cmd;
	logic signed [svq_pkg::DATA_W-1:0] cell_val [N];
	logic [N-1:0]                     cell_vld;
	logic [N-1:0]                     cell_le;
	logic [N-1:0]                     cell_eq;
	logic                             accept;
	logic                             full;
	logic                             empty;
	logic                             found;
	logic                             done_q;
	logic                             not_found_q;
	logic                             dropped_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = cell_vld[N-1];
	assign empty  = !cell_vld[0];
	assign found  = |cell_eq;

	// decode the request into the broadcast cell operation
	always_comb begin
		cmd.key = value;
		cmd.op  = svq_pkg::CELL_HOLD;
		if (accept) begin
			case (func)
				svq_pkg::FUNC_INSERT: begin
					if (!full) cmd.op = svq_pkg::CELL_INSERT;
				end
				svq_pkg::FUNC_REMOVE: begin
					if (found) cmd.op = svq_pkg::CELL_REMOVE;
				end
				svq_pkg::FUNC_POP: begin
					if (!empty) cmd.op = svq_pkg::CELL_POP;
				end
				default: cmd.op = svq_pkg::CELL_HOLD;
			endcase
		end
	end

	// row of cells, each linked to its neighbors
	for (genvar i = 0; i < N; i++) begin : g_cell
		svq_pkg::cell_flags_t flags;
		logic signed [svq_pkg::DATA_W-1:0] l_val;
		logic signed [svq_pkg::DATA_W-1:0] r_val;
		logic l_vld;
		logic l_le;
		logic r_vld;

		if (i == 0) begin : g_first
			// head of the row takes the key when nothing sits before it
			assign l_val = '0;
			assign l_vld = 1'b1;
			assign l_le  = 1'b1;
		end else begin : g_mid
			assign l_val = cell_val[i-1];
			assign l_vld = cell_vld[i-1];
			assign l_le  = cell_le[i-1];
		end

		if (i == N-1) begin : g_last
			assign r_val = '0;
			assign r_vld = 1'b0;
		end else begin : g_inner
			assign r_val = cell_val[i+1];
			assign r_vld = cell_vld[i+1];
		end

		svq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left_val  (l_val),
			.left_vld  (l_vld),
			.left_le   (l_le),
			.right_val (r_val),
			.right_vld (r_vld),
			.val       (cell_val[i]),
			.vld       (cell_vld[i]),
			.flags     (flags)
		);

		assign cell_le[i] = flags.le;
		assign cell_eq[i] = flags.eq;
	end

	// result strobe and status flags of the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			not_found_q <= 1'b0;
			dropped_q   <= 1'b0;
		end else begin
			done_q      <= accept;
			not_found_q <= accept && (func == svq_pkg::FUNC_REMOVE) && !found;
			dropped_q   <= accept && (func == svq_pkg::FUNC_INSERT) && full;
		end
	end

	// head cell already holds the state after the request
	assign done      = done_q;
	assign is_empty  = !cell_vld[0];
	assign smallest  = cell_vld[0] ? cell_val[0] : svq_pkg::EMPTY_MARK;
	assign not_found = not_found_q;
	assign dropped   = dropped_q;

endmodule
